[src/encps_pkg.sv]
`timescale 1ns / 1ps

package encps_pkg;

    localparam int CmdWidth    = 3;
    localparam int TimerWidth  = 16;
    localparam int TickWidth   = 17;
    localparam int CountWidth  = 32;
    localparam int OvfWidth    = 8;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 32;
    localparam int InDataWidth  = 24;
    localparam int OutDataWidth = 152;

    localparam logic [CmdWidth-1:0] CMD_A_EDGE   = 3'd0;
    localparam logic [CmdWidth-1:0] CMD_B_EDGE   = 3'd1;
    localparam logic [CmdWidth-1:0] CMD_INDEX    = 3'd2;
    localparam logic [CmdWidth-1:0] CMD_OVERFLOW = 3'd3;
    localparam logic [CmdWidth-1:0] CMD_CLEAR    = 3'd4;

    localparam logic [CfgIdxWidth-1:0] REG_TICKS_PER_REV     = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_TIMER_PERIOD      = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_TIMEOUT_OVERFLOWS = 2'd2;
    localparam logic [CfgIdxWidth-1:0] REG_SPEED_NUMERATOR   = 2'd3;

    localparam logic [15:0] RST_TICKS_PER_REV     = 16'd1000;
    localparam logic [15:0] RST_TIMER_PERIOD      = 16'd50000;
    localparam logic [7:0]  RST_TIMEOUT_OVERFLOWS = 8'd20;
    localparam logic [31:0] RST_SPEED_NUMERATOR   = 32'd60000;

endpackage

[src/encoder_position_and_speed.sv]
`timescale 1ns / 1ps
// Each accepted input word passes through an update state, a 32-step restoring
// divider with one quotient bit per cycle, and an output load before its result
// word is valid; no new input word is taken until the previous one is loaded.
// Reset: synchronous, active low; counters clear, registers return to defaults.
// The next input word is taken while a finished result still waits downstream.

module encoder_position_and_speed (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // timer_count[15:0], line_a_level[16], zero [23:17]
    input  logic [23:0]  s_axis_tdata,
    // command[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tick_count[16:0], rev_count[48:17], index_count[80:49], direction[81],
    // rotating[82], period_width[114:83], speed[146:115], zero [151:147]
    output logic [151:0] m_axis_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    t_state r_state;

    logic [15:0] r_ticks_per_rev;
    logic [15:0] r_timer_period;
    logic [7:0]  r_timeout;
    logic [31:0] r_numerator;

    logic [2:0]  r_cmd;
    logic [15:0] r_tcount;
    logic        r_alevel;

    logic signed [16:0] r_ticks;
    logic [31:0] r_revs;
    logic [31:0] r_index;
    logic        r_dir;
    logic        r_moving;
    logic [7:0]  r_ovf;
    logic [15:0] r_last;
    logic [31:0] r_period;

    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [4:0]  r_bit;

    logic        r_m_tvalid;
    logic [151:0] r_m_tdata;

    logic signed [17:0] n_tick_step;
    logic signed [17:0] w_lim;
    logic        w_wrap_up;
    logic        w_wrap_dn;
    logic [23:0] w_prod;
    logic [31:0] n_period;
    logic [7:0]  n_ovf;
    logic [32:0] w_rem_shift;
    logic [32:0] w_diff;
    logic [31:0] w_speed;
    logic        w_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    always_comb begin
        n_tick_step = {r_ticks[16], r_ticks} + (r_dir ? 18'sd1 : -18'sd1);
        w_lim       = signed'({2'b00, r_ticks_per_rev});
        w_wrap_up   = (n_tick_step >= w_lim);
        w_wrap_dn   = (n_tick_step <= -w_lim);
        w_prod      = {16'd0, r_ovf} * {8'd0, r_timer_period};
        n_period    = {16'd0, r_tcount} - {16'd0, r_last} + {8'd0, w_prod};
        n_ovf       = (r_ovf == 8'hFF) ? r_ovf : r_ovf + 8'd1;
        w_rem_shift = {r_rem, r_quo[31]};
        w_diff      = w_rem_shift - {1'b0, r_period};
        w_speed     = (r_moving && (r_period != 32'd0)) ? r_quo : 32'd0;
        w_load      = (r_state == ST_DONE) && (!r_m_tvalid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_rev <= encps_pkg::RST_TICKS_PER_REV;
            r_timer_period  <= encps_pkg::RST_TIMER_PERIOD;
            r_timeout       <= encps_pkg::RST_TIMEOUT_OVERFLOWS;
            r_numerator     <= encps_pkg::RST_SPEED_NUMERATOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                encps_pkg::REG_TICKS_PER_REV:     r_ticks_per_rev <= i_cfg_wdata[15:0];
                encps_pkg::REG_TIMER_PERIOD:      r_timer_period  <= i_cfg_wdata[15:0];
                encps_pkg::REG_TIMEOUT_OVERFLOWS: r_timeout       <= i_cfg_wdata[7:0];
                encps_pkg::REG_SPEED_NUMERATOR:   r_numerator     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ticks    <= '0;
            r_revs     <= '0;
            r_index    <= '0;
            r_dir      <= 1'b0;
            r_moving   <= 1'b0;
            r_ovf      <= '0;
            r_last     <= '0;
            r_period   <= '0;
            r_bit      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= s_axis_tuser;
                        r_tcount <= s_axis_tdata[15:0];
                        r_alevel <= s_axis_tdata[16];
                        r_state  <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    unique case (r_cmd)
                        encps_pkg::CMD_A_EDGE: begin
                            if (w_wrap_up) begin
                                r_revs  <= r_revs + 32'd1;
                                r_ticks <= '0;
                            end else if (w_wrap_dn) begin
                                r_revs  <= r_revs - 32'd1;
                                r_ticks <= '0;
                            end else begin
                                r_ticks <= n_tick_step[16:0];
                            end
                            r_period <= r_moving ? n_period : 32'd0;
                            r_moving <= 1'b1;
                            r_ovf    <= '0;
                            r_last   <= r_tcount;
                        end
                        encps_pkg::CMD_B_EDGE: r_dir <= ~r_alevel;
                        encps_pkg::CMD_INDEX:
                            r_index <= r_dir ? r_index + 32'd1 : r_index - 32'd1;
                        encps_pkg::CMD_OVERFLOW: begin
                            r_ovf <= n_ovf;
                            if (n_ovf >= r_timeout) begin
                                r_moving <= 1'b0;
                            end
                        end
                        encps_pkg::CMD_CLEAR: r_ticks <= '0;
                        default: ;
                    endcase
                    r_quo   <= r_numerator;
                    r_rem   <= '0;
                    r_bit   <= '0;
                    r_state <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (!w_diff[32]) begin
                        r_rem <= w_diff[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_shift[31:0];
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd31) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (w_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_tdata <= {5'd0, w_speed, r_period, r_moving, r_dir,
                          r_index, r_revs, r_ticks};
        end
    end

endmodule

[src/encps_checker.sv]
`timescale 1ns / 1ps

module encps_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [151:0] m_axis_tdata
);

    // hold the input closed while a word is at work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again right after accept");

    // a stalled result word must hold
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

    // speed is zero when not rotating or when the period is unknown
    a_speed_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (!m_axis_tdata[82] || (m_axis_tdata[114:83] == 32'd0)))
            |-> (m_axis_tdata[146:115] == 32'd0))
        else $error("nonzero speed while stopped");

    // tick count never reaches minus 65536
    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] != 17'h10000))
        else $error("tick count out of range");

endmodule

bind encoder_position_and_speed encps_checker u_encps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
